/* design/erbr_pkg.sv */
// Shared types, constants and helpers for the event ring buffer reader.
package erbr_pkg;

  localparam int DEPTH           = 4096;
  localparam int MAX_EVENT_WORDS = 64;
  localparam int PTR_W           = $clog2(DEPTH);
  localparam int RS_W            = PTR_W + 1;
  localparam int CFG_W           = 13;
  localparam int N_W             = $clog2(MAX_EVENT_WORDS + 1);
  localparam int WORD_W          = 32;

  typedef enum logic [2:0] {
    STATUS_OK     = 3'd0,
    STATUS_LOCKED = 3'd1,
    STATUS_EMPTY  = 3'd2,
    STATUS_FAILED = 3'd3,
    STATUS_FULL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    FILL_EMPTY = 2'd0,
    FILL_FREE  = 2'd1,
    FILL_FULL  = 2'd2
  } fill_t;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_t;

  // Result of the header check handed back to the controller.
  typedef struct packed {
    logic             ok;
    logic [N_W-1:0]   n;
    logic [PTR_W-1:0] newrp;
  } hdr_res_t;

  // Ring size in use: values below two act as two, values above DEPTH as DEPTH.
  function automatic logic [RS_W-1:0] ring_size(input logic [CFG_W-1:0] cfg);
    logic [RS_W-1:0] r;
    begin
      if (cfg < CFG_W'(2)) begin
        r = RS_W'(2);
      end else if (cfg > CFG_W'(DEPTH)) begin
        r = RS_W'(DEPTH);
      end else begin
        r = RS_W'(cfg);
      end
      return r;
    end
  endfunction

  // Pointer advance with wrap at the ring size.
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [RS_W-1:0] r);
    logic [RS_W-1:0] s;
    begin
      s = {1'b0, p} + RS_W'(1);
      return (s >= r) ? '0 : s[PTR_W-1:0];
    end
  endfunction

endpackage

/* design/erbr_ram.sv */
// Single-port synchronous RAM with registered read data.
module erbr_ram #(
  parameter int AW = 12,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* design/erbr_hdr_check.sv */
// Event header check: length decode and overrun test against the write pointer.
module erbr_hdr_check (
  input  logic [erbr_pkg::WORD_W-1:0] hdr,
  input  logic [erbr_pkg::PTR_W-1:0]  rp,
  input  logic [erbr_pkg::PTR_W-1:0]  wp,
  input  logic [erbr_pkg::RS_W-1:0]   rsize,
  output erbr_pkg::hdr_res_t          res
);

  logic [erbr_pkg::WORD_W-3:0] len;
  logic                        len_ok;
  logic [erbr_pkg::RS_W-1:0]   ev_end;
  logic [erbr_pkg::RS_W-1:0]   ev_wrap;

  always_comb begin
    // The header counts bytes; partial words are dropped.
    len     = hdr[erbr_pkg::WORD_W-1:2];
    len_ok  = (len != '0) && (len <= (erbr_pkg::WORD_W-2)'(erbr_pkg::MAX_EVENT_WORDS));
    ev_end  = {1'b0, rp} + erbr_pkg::RS_W'(len[erbr_pkg::N_W-1:0]);
    ev_wrap = ev_end - rsize;
    res.n     = len[erbr_pkg::N_W-1:0];
    res.ok    = 1'b0;
    res.newrp = ev_end[erbr_pkg::PTR_W-1:0];
    if (len_ok) begin
      if (rp >= wp) begin
        if (ev_end < rsize) begin
          res.ok = 1'b1;
        end else if (ev_wrap <= {1'b0, wp}) begin
          res.ok    = 1'b1;
          res.newrp = ev_wrap[erbr_pkg::PTR_W-1:0];
        end
      end else if (ev_end <= {1'b0, wp}) begin
        res.ok = 1'b1;
      end
    end
  end

endmodule

/* design/event_ring_buffer_reader.sv */
// Event ring buffer reader: ring store of 32-bit words with event-wise readout.
//
// The block holds a ring of 32-bit words in a single-port RAM together with a
// read pointer, a write pointer and a fill mark. An input word with tuser set
// to write stores one data word at the write pointer, unless the ring is full,
// and answers with one status word. An input word with tuser set to read
// answers a single status word when the writer holds the lock or the ring is
// empty. Otherwise the header at the read pointer is fetched, its byte length
// is checked against the write pointer, and the whole event, header first, is
// streamed out one word per cycle while the master side is ready, wrapping at
// the configured ring size; a failed check answers a single status word. The
// one RAM port delivers one stored word per cycle. The user must write the
// ring size register only while the block is idle; the block itself does not
// enforce this. A write also empties the ring. The store needs no clearing
// after reset, since only written words are ever read. The output register lets
// a new input word be taken while a result still waits on the master side.
module event_ring_buffer_reader (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration: ring size in words.
  input  logic                        cfg_wen,
  input  logic [erbr_pkg::CFG_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [39:0]                 s_axis_tdata,  // write_word[31:0], writer_busy[32]
  input  logic [0:0]                  s_axis_tuser,  // func[0]
  // Result stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [39:0]                 m_axis_tdata,  // data_word[31:0], event_words[38:32]
  output logic [2:0]                  m_axis_tuser,  // status[2:0]
  output logic                        m_axis_tlast   // last
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_STREAM,
    ST_EMIT
  } state_t;

  state_t                       state;
  logic [erbr_pkg::CFG_W-1:0]   ring_words;
  logic [erbr_pkg::RS_W-1:0]    rsize;
  logic [erbr_pkg::PTR_W-1:0]   rp;
  logic [erbr_pkg::PTR_W-1:0]   wp;
  logic [erbr_pkg::PTR_W-1:0]   wp_inc;
  erbr_pkg::fill_t              fill;

  // Pending single-word result.
  erbr_pkg::status_t            res_status;

  // Stream bookkeeping.
  logic [erbr_pkg::PTR_W-1:0]   rd_addr;
  logic [erbr_pkg::PTR_W-1:0]   newrp;
  logic [erbr_pkg::N_W-1:0]     ev_words;
  logic [erbr_pkg::N_W-1:0]     issued;
  logic [erbr_pkg::N_W-1:0]     sent;
  logic                         rd_valid;

  // Output register.
  logic                         m_valid;
  erbr_pkg::status_t            m_status;
  logic [erbr_pkg::WORD_W-1:0]  m_data;
  logic [erbr_pkg::N_W-1:0]     m_words;
  logic                         m_last;

  logic                         accept;
  erbr_pkg::func_t              in_func;
  logic [erbr_pkg::WORD_W-1:0]  in_word;
  logic                         in_busy;
  logic                         is_empty;
  logic                         out_free;
  logic                         consume;
  logic                         issue;
  logic                         out_load;

  logic                         ram_en;
  logic                         ram_we;
  logic [erbr_pkg::PTR_W-1:0]   ram_addr;
  logic [erbr_pkg::WORD_W-1:0]  ram_rdata;
  erbr_pkg::hdr_res_t           hres;

  assign rsize    = erbr_pkg::ring_size(ring_words);
  assign in_func  = erbr_pkg::func_t'(s_axis_tuser[0]);
  assign in_word  = s_axis_tdata[31:0];
  assign in_busy  = s_axis_tdata[32];
  assign is_empty = (rp == wp) && (fill == erbr_pkg::FILL_EMPTY);
  assign wp_inc   = erbr_pkg::ptr_inc(wp, rsize);

  // A ring size write takes the cycle; no input word is taken alongside it.
  assign s_axis_tready = (state == ST_IDLE) && !cfg_wen;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign out_free = !m_valid || m_axis_tready;
  assign consume  = (state == ST_STREAM) && rd_valid && out_free && !cfg_wen;
  // A new RAM read goes out only when the read register is empty or the word now in it leaves.
  assign issue    = (state == ST_STREAM) && (issued < ev_words) && (!rd_valid || consume);
  // The output register is loaded by an event word or by a single status word.
  assign out_load = consume || ((state == ST_EMIT) && out_free && !cfg_wen);

  always_comb begin
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = rd_addr;
    if (accept) begin
      if (in_func == erbr_pkg::FUNC_WRITE) begin
        ram_addr = wp;
        if (fill != erbr_pkg::FILL_FULL) begin
          ram_en = 1'b1;
          ram_we = 1'b1;
        end
      end else begin
        ram_addr = rp;
        ram_en   = !in_busy && !is_empty;
      end
    end else if (issue) begin
      ram_en = 1'b1;
    end
  end

  erbr_ram #(
    .AW (erbr_pkg::PTR_W),
    .DW (erbr_pkg::WORD_W)
  ) u_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_word),
    .rdata (ram_rdata)
  );

  erbr_hdr_check u_hdr_check (
    .hdr   (ram_rdata),
    .rp    (rp),
    .wp    (wp),
    .rsize (rsize),
    .res   (hres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      ring_words <= erbr_pkg::CFG_W'(erbr_pkg::DEPTH);
      rp         <= '0;
      wp         <= '0;
      fill       <= erbr_pkg::FILL_EMPTY;
      rd_valid   <= 1'b0;
      m_valid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      if (cfg_wen) begin
        // A new ring size empties the ring.
        ring_words <= cfg_wdata;
        rp         <= '0;
        wp         <= '0;
        fill       <= erbr_pkg::FILL_EMPTY;
      end else begin
        case (state)
          ST_IDLE: begin
            if (accept) begin
              state <= ST_EMIT;
              if (in_func == erbr_pkg::FUNC_WRITE) begin
                if (fill == erbr_pkg::FILL_FULL) begin
                  res_status <= erbr_pkg::STATUS_FULL;
                end else begin
                  res_status <= erbr_pkg::STATUS_OK;
                  wp         <= wp_inc;
                  fill       <= (wp_inc == rp) ? erbr_pkg::FILL_FULL : erbr_pkg::FILL_FREE;
                end
              end else if (in_busy) begin
                res_status <= erbr_pkg::STATUS_LOCKED;
              end else if (is_empty) begin
                res_status <= erbr_pkg::STATUS_EMPTY;
              end else begin
                state <= ST_HDR;
              end
            end
          end
          ST_HDR: begin
            // The header sits in the RAM read register and stays there as word 0.
            if (hres.ok) begin
              state    <= ST_STREAM;
              ev_words <= hres.n;
              newrp    <= hres.newrp;
              rd_addr  <= erbr_pkg::ptr_inc(rp, rsize);
              issued   <= erbr_pkg::N_W'(1);
              sent     <= '0;
              rd_valid <= 1'b1;
            end else begin
              state      <= ST_EMIT;
              res_status <= erbr_pkg::STATUS_FAILED;
            end
          end
          ST_STREAM: begin
            if (issue) begin
              rd_addr <= erbr_pkg::ptr_inc(rd_addr, rsize);
              issued  <= issued + erbr_pkg::N_W'(1);
            end
            if (issue) begin
              rd_valid <= 1'b1;
            end else if (consume) begin
              rd_valid <= 1'b0;
            end
            if (consume) begin
              m_status <= erbr_pkg::STATUS_OK;
              m_data   <= ram_rdata;
              m_words  <= ev_words;
              m_last   <= (sent + erbr_pkg::N_W'(1) == ev_words);
              sent     <= sent + erbr_pkg::N_W'(1);
              if (sent + erbr_pkg::N_W'(1) == ev_words) begin
                state <= ST_IDLE;
                rp    <= newrp;
                fill  <= (newrp == wp) ? erbr_pkg::FILL_EMPTY : erbr_pkg::FILL_FREE;
              end
            end
          end
          ST_EMIT: begin
            if (out_free) begin
              state    <= ST_IDLE;
              m_status <= res_status;
              m_data   <= '0;
              m_words  <= '0;
              m_last   <= 1'b1;
            end
          end
          default: begin
            state <= ST_IDLE;
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {1'b0, m_words, m_data};
  assign m_axis_tuser  = m_status;
  assign m_axis_tlast  = m_last;

  // The RAM read register holds a word only while an event streams out.
  a_rd_valid_stream: assert property (@(posedge clk) disable iff (rst)
    (state != ST_STREAM) |-> !rd_valid)
    else $error("read data marked valid outside an event readout");

  // A full or empty ring always has its two pointers together.
  a_fill_ptrs: assert property (@(posedge clk) disable iff (rst)
    (fill == erbr_pkg::FILL_FULL || fill == erbr_pkg::FILL_EMPTY) |-> (rp == wp))
    else $error("fill mark disagrees with the pointers");

  // Pointers stay inside the ring in use.
  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, rp} < rsize) && ({1'b0, wp} < rsize))
    else $error("pointer beyond the ring size");

  // No more reads go out than the event has words.
  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STREAM) |-> (issued <= ev_words) && (sent < issued))
    else $error("event readout count out of step");

  // Any result other than an event word closes its item.
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (m_valid && m_status != erbr_pkg::STATUS_OK) |-> m_last)
    else $error("status result not marked last");

endmodule

/* tb/event_ring_buffer_reader_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the event ring buffer reader with a built-in ring predictor.
module event_ring_buffer_reader_tb;

  // The receiver's long hold-off, used once to fill the block and stall its input.
  localparam int HOLD_CYCLES    = 400;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 4000;
  // Settling time after the last expected word.
  localparam int SETTLE_CYCLES  = 80;

  // One input word as the sender sees it.
  typedef struct packed {
    erbr_pkg::func_t             func;
    logic                        busy;
    logic [erbr_pkg::WORD_W-1:0] word;
  } request_t;

  // One result word as the receiver sees it.
  typedef struct packed {
    erbr_pkg::status_t           status;
    logic [erbr_pkg::WORD_W-1:0] data;
    logic [erbr_pkg::N_W-1:0]    nwords;
    logic                        last;
  } result_t;

  // All block inputs start at known values.
  logic                       clk           = 1'b0;
  logic                       rst           = 1'b1;
  logic                       cfg_wen       = 1'b0;
  logic [erbr_pkg::CFG_W-1:0] cfg_wdata     = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic [39:0]                s_axis_tdata  = '0;
  logic [0:0]                 s_axis_tuser  = '0;
  logic                       m_axis_tready = 1'b0;
  logic                       s_axis_tready;
  logic                       m_axis_tvalid;
  logic [39:0]                m_axis_tdata;
  logic [2:0]                 m_axis_tuser;
  logic                       m_axis_tlast;

  // Predictor state: the ring contents, both pointers, the fill mark and the size register.
  logic [erbr_pkg::WORD_W-1:0] ring_mem [erbr_pkg::DEPTH];
  logic [erbr_pkg::PTR_W-1:0]  rd_ptr;
  logic [erbr_pkg::PTR_W-1:0]  wr_ptr;
  erbr_pkg::fill_t             fill_state;
  logic [erbr_pkg::CFG_W-1:0]  ring_cfg;

  // Words waiting to be sent, and result words predicted but not yet seen.
  request_t pending_words[$];
  result_t  expected_results[$];

  // The stimulus plan tracks how full the ring will be, so that most sequences stay
  // well formed: events only fit into free space and reads consume whole events.
  int plan_ring;
  int plan_fill;
  int plan_lens[$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_cmd;
  int stall_seen;
  int hold_left;
  int idle_cycles;
  int errors;
  int words_sent;
  int results_seen;
  int status_hits [0:4];

  request_t current_word;

  event_ring_buffer_reader uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // write_word[31:0], writer_busy[32]
    .s_axis_tuser  (s_axis_tuser),   // func[0]
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // data_word[31:0], event_words[38:32]
    .m_axis_tuser  (m_axis_tuser),   // status[2:0]
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Sizes 0 and 1 behave as 2, anything above the store depth as the full store.
  function automatic int clamp_ring(input int v);
    return (v < 2) ? 2 : ((v > erbr_pkg::DEPTH) ? erbr_pkg::DEPTH : v);
  endfunction

  task automatic expect_result(input erbr_pkg::status_t st,
                               input logic [erbr_pkg::WORD_W-1:0] d,
                               input int n, input logic fin);
    result_t r;
    r = '{status: st, data: d, nwords: erbr_pkg::N_W'(n), last: fin};
    expected_results.push_back(r);
    status_hits[int'(st)]++;
  endtask

  // Works out the result words of one accepted input word and updates the ring state.
  task automatic predict_word(input request_t req);
    int unsigned r;
    int unsigned rp;
    int unsigned wp;
    int unsigned n;
    int unsigned stop;
    int unsigned next_rp;
    int unsigned a;
    bit          overrun;
    r = clamp_ring(int'(ring_cfg));
    if (req.func == erbr_pkg::FUNC_WRITE) begin
      // Writes ignore the lock; a full ring rejects the word and keeps everything.
      if (fill_state == erbr_pkg::FILL_FULL) begin
        expect_result(erbr_pkg::STATUS_FULL, '0, 0, 1'b1);
        return;
      end
      ring_mem[wr_ptr] = req.word;
      wp = wr_ptr + 1;
      if (wp >= r) wp = 0;
      wr_ptr = erbr_pkg::PTR_W'(wp);
      fill_state = (wr_ptr == rd_ptr) ? erbr_pkg::FILL_FULL : erbr_pkg::FILL_FREE;
      expect_result(erbr_pkg::STATUS_OK, '0, 0, 1'b1);
      return;
    end
    if (req.busy) begin
      expect_result(erbr_pkg::STATUS_LOCKED, '0, 0, 1'b1);
      return;
    end
    rp = rd_ptr;
    wp = wr_ptr;
    if (rp == wp && fill_state == erbr_pkg::FILL_EMPTY) begin
      expect_result(erbr_pkg::STATUS_EMPTY, '0, 0, 1'b1);
      return;
    end
    // The header holds the length in bytes; leftover bytes of a partial word are dropped.
    n = ring_mem[rp] >> 2;
    if (n == 0 || n > erbr_pkg::MAX_EVENT_WORDS) begin
      expect_result(erbr_pkg::STATUS_FAILED, '0, 0, 1'b1);
      return;
    end
    stop    = rp + n;
    overrun = 1'b0;
    next_rp = 0;
    if (rp >= wp) begin
      // The written span wraps (or the ring is full): the event may wrap up to wp.
      if (stop < r) next_rp = stop;
      else if (stop - r <= wp) next_rp = stop - r;
      else overrun = 1'b1;
    end else begin
      if (stop <= wp) next_rp = stop;
      else overrun = 1'b1;
    end
    if (overrun) begin
      expect_result(erbr_pkg::STATUS_FAILED, '0, 0, 1'b1);
      return;
    end
    for (int unsigned i = 0; i < n; i++) begin
      a = rp + i;
      if (a >= r) a -= r;
      expect_result(erbr_pkg::STATUS_OK, ring_mem[a], n, (i + 1 == n));
    end
    rd_ptr     = erbr_pkg::PTR_W'(next_rp);
    fill_state = (next_rp == wp) ? erbr_pkg::FILL_EMPTY : erbr_pkg::FILL_FREE;
  endtask

  task automatic note_failure(input string msg);
    if (errors < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic push_word(input erbr_pkg::func_t f, input logic busy,
                           input logic [erbr_pkg::WORD_W-1:0] w);
    request_t req;
    req = '{func: f, busy: busy, word: w};
    pending_words.push_back(req);
  endtask

  // A random lock flag for write words, which the block ignores.
  function automatic logic rand_busy();
    return 1'($urandom_range(0, 1));
  endfunction

  // A read that is not locked consumes the oldest planned event, if there is one.
  task automatic add_read(input logic busy);
    push_word(erbr_pkg::FUNC_READ, busy, $urandom());
    if (!busy && plan_lens.size() > 0) plan_fill -= plan_lens.pop_front();
  endtask

  // A whole event: header with a random byte remainder, then n - 1 random words.
  task automatic add_event(input int n);
    push_word(erbr_pkg::FUNC_WRITE, rand_busy(), 32'(n << 2) | 32'($urandom_range(0, 3)));
    repeat (n - 1) push_word(erbr_pkg::FUNC_WRITE, rand_busy(), $urandom());
    plan_fill += n;
    plan_lens.push_back(n);
  endtask

  // Random traffic of about the given number of input words at the current ring size.
  task automatic run_random(input int count);
    int left;
    int pick;
    int free_words;
    int cap;
    int n;
    int k;
    left = count;
    // Open large rings with a maximum-length event.
    if (plan_ring >= erbr_pkg::MAX_EVENT_WORDS) begin
      add_event(erbr_pkg::MAX_EVENT_WORDS);
      left -= erbr_pkg::MAX_EVENT_WORDS;
    end
    while (left > 0) begin
      free_words = plan_ring - plan_fill;
      cap        = (free_words < erbr_pkg::MAX_EVENT_WORDS) ? free_words
                                                            : erbr_pkg::MAX_EVENT_WORDS;
      pick       = $urandom_range(0, 99);
      if (pick < 45 && free_words > 0) begin
        // Mostly short events, now and then long ones, sometimes exactly filling the ring.
        k = $urandom_range(0, 19);
        if (k == 0) n = cap;
        else if (k < 3) n = $urandom_range(1, cap);
        else n = $urandom_range(1, (cap < 8) ? cap : 8);
        add_event(n);
        left -= n;
      end else if (pick < 55 && free_words >= 2) begin
        // An event read before its tail is written, then completed.
        n = $urandom_range(2, cap);
        k = $urandom_range(0, n - 2);
        push_word(erbr_pkg::FUNC_WRITE, rand_busy(),
                  32'(n << 2) | 32'($urandom_range(0, 3)));
        repeat (k) push_word(erbr_pkg::FUNC_WRITE, rand_busy(), $urandom());
        add_read(1'b0);
        repeat (n - 1 - k) push_word(erbr_pkg::FUNC_WRITE, rand_busy(), $urandom());
        plan_fill += n;
        plan_lens.push_back(n);
        left -= n + 1;
      end else if (pick < 60 && free_words == 0) begin
        // Write into a full ring: rejected and harmless.
        push_word(erbr_pkg::FUNC_WRITE, rand_busy(), $urandom());
        left--;
      end else begin
        add_read($urandom_range(0, 9) == 0);
        left--;
      end
    end
    // Drain the ring, then leave a malformed header that the next read must reject.
    while (plan_lens.size() > 0) add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, rand_busy(),
              ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : ($urandom() | 32'h400));
    add_read(1'b0);
    add_read(1'b1);
  endtask

  // Writing the size register also empties the ring, in the block and in the predictor.
  task automatic set_ring(input logic [erbr_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_wen    <= 1'b1;
    cfg_wdata  <= v;
    ring_cfg   = v;
    rd_ptr     = '0;
    wr_ptr     = '0;
    fill_state = erbr_pkg::FILL_EMPTY;
    plan_ring  = clamp_ring(int'(v));
    plan_fill  = 0;
    plan_lens.delete();
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Waits until every queued word is sent and every predicted word has come back.
  task automatic wait_idle();
    while (pending_words.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sender: holds a word until it is taken, then runs the predictor on it. Between
  // words it may idle, at the rate set for the current phase.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_word(current_word);
        words_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          current_word = pending_words.pop_front();
          s_axis_tdata  <= {7'b0, current_word.busy, current_word.word};
          s_axis_tuser  <= current_word.func;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each taken word against the oldest prediction, then decides
  // whether to stall next cycle. A new stall request starts the long hold-off.
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result word with nothing expected: status %0d data %h",
                                 m_axis_tuser, m_axis_tdata[31:0]));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata[31:0] !== want.data ||
              m_axis_tdata[38:32] !== want.nwords || m_axis_tlast !== want.last)
            note_failure($sformatf(
              "expected status %0d data %h words %0d last %0b, got %0d %h %0d %0b",
              want.status, want.data, want.nwords, want.last,
              m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[38:32], m_axis_tlast));
        end
      end
      if (stall_cmd != stall_seen) begin
        stall_seen = stall_cmd;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: any accepted word on either side restarts the count.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word accepted for %0d cycles.", WATCHDOG_LIMIT);
        $display("status: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    ring_cfg      = erbr_pkg::CFG_W'(erbr_pkg::DEPTH);
    rd_ptr        = '0;
    wr_ptr        = '0;
    fill_state    = erbr_pkg::FILL_EMPTY;
    plan_ring     = erbr_pkg::DEPTH;
    plan_fill     = 0;
    stall_cmd     = 0;
    stall_seen    = 0;
    hold_left     = 0;
    idle_cycles   = 0;
    errors        = 0;
    words_sent    = 0;
    results_seen  = 0;
    status_hits   = '{default: 0};
    send_idle_pct = 22;
    recv_idle_pct = 88;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset ring size: empty and locked reads, a one-word
    // event, an event with all-ones and all-zeros data, a read that overruns an
    // incomplete event, and a header longer than the largest event.
    add_read(1'b0);
    add_read(1'b1);
    push_word(erbr_pkg::FUNC_WRITE, 1'b1, 32'h0000_0007);
    add_read(1'b1);
    add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_000C);
    push_word(erbr_pkg::FUNC_WRITE, 1'b1, 32'hFFFF_FFFF);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_0000);
    add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_0008);
    add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h5A5A_A5A5);
    add_read(1'b0);
    add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_0104);
    add_read(1'b0);
    wait_idle();

    // Size 0 acts as the two-word minimum: fill it, write into the full ring,
    // read the whole ring back, then reject a zero-length header.
    set_ring('0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_0008);
    push_word(erbr_pkg::FUNC_WRITE, 1'b1, 32'hFFFF_FFFF);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h1234_5678);
    add_read(1'b0);
    add_read(1'b0);
    push_word(erbr_pkg::FUNC_WRITE, 1'b0, 32'h0000_0003);
    add_read(1'b0);
    wait_idle();

    // All-ones register value clamps to the full store.
    set_ring('1);
    run_random(65);
    wait_idle();

    send_idle_pct = 88;
    recv_idle_pct = 22;
    set_ring(erbr_pkg::CFG_W'(8));
    run_random(40);
    wait_idle();
    set_ring(erbr_pkg::CFG_W'(2));
    run_random(25);
    wait_idle();

    // No idling from here on; the first phase starts with the long receiver hold-off.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_ring(erbr_pkg::CFG_W'(erbr_pkg::DEPTH));
    stall_cmd++;
    run_random(65);
    wait_idle();
    set_ring(erbr_pkg::CFG_W'(37));
    run_random(25);
    wait_idle();
    set_ring(erbr_pkg::CFG_W'(130));
    run_random(20);
    wait_idle();

    if (expected_results.size() != 0)
      note_failure($sformatf("%0d expected result words never arrived",
                             expected_results.size()));
    $display("Sent %0d input words and checked %0d result words over ring sizes 2 to %0d.",
             words_sent, results_seen, erbr_pkg::DEPTH);
    $display("Result words by status: ok %0d, locked %0d, empty %0d, failed %0d, full %0d.",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3], status_hits[4]);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
